>>> hw/rtl/ata_tfb_pkg.sv
package ata_tfb_pkg;

	// Configuration port widths and register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLAGS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY0   = 3'd1;

	// Per-entry flag bit positions within a five-bit drive entry.
	localparam int FLAG_W       = 5;
	localparam int FLAG_PRESENT = 0;
	localparam int FLAG_CHANNEL = 1;
	localparam int FLAG_SLAVE   = 2;
	localparam int FLAG_LBA48   = 3;
	localparam int FLAG_LBA     = 4;

	// Error codes.
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_NOT_FOUND = 2'd1;
	localparam logic [1:0] ERR_RANGE     = 2'd2;

	// Addressing modes.
	localparam logic [1:0] MODE_CHS   = 2'd0;
	localparam logic [1:0] MODE_LBA28 = 2'd1;
	localparam logic [1:0] MODE_LBA48 = 2'd2;

	// Task-file constants.
	localparam logic [7:0] DEV_CHS        = 8'hA0;
	localparam logic [7:0] DEV_LBA        = 8'hE0;
	localparam logic [7:0] CMD_READ       = 8'h20;
	localparam logic [7:0] CMD_READ_EXT   = 8'h24;
	localparam logic [7:0] CMD_WRITE      = 8'h30;
	localparam logic [7:0] CMD_WRITE_EXT  = 8'h34;
	localparam logic [7:0] CMD_FLUSH      = 8'hE7;
	localparam logic [7:0] CMD_FLUSH_EXT  = 8'hEA;
	localparam logic [7:0] CMD_NONE       = 8'h00;

	// Division by 63 sectors per track: floor(2^37 / 63), quotient in bits 63:37.
	localparam logic [31:0] RECIP_63    = 32'd2181570690;
	localparam int          RECIP_SHIFT = 37;
	localparam int          QUOT_W      = 27;
	localparam logic [6:0]  SPT         = 7'd63;

	// Widths of the stream words.
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 72;

	// Request after the capacity check, with the quotient estimate.
	typedef struct packed {
		logic [1:0]        error_code;
		logic              channel;
		logic              slave;
		logic [1:0]        mode;
		logic              write_request;
		logic [7:0]        sector_count;
		logic [31:0]       block_address;
		logic [QUOT_W-1:0] quot_est;
	} checked_req_t;

	// Result word, last field in the lowest bits.
	typedef struct packed {
		logic [7:0] flush_command;
		logic [7:0] command_byte;
		logic [7:0] device_select;
		logic [7:0] address_byte3;
		logic [7:0] address_byte2;
		logic [7:0] address_byte1;
		logic [7:0] address_byte0;
		logic [7:0] count_byte;
		logic [1:0] address_mode;
		logic       channel_select;
		logic [1:0] error_code;
	} taskfile_t;

endpackage

>>> hw/rtl/ata_tfb_check.sv
module ata_tfb_check #(
	parameter int NUM_DRIVES = 4
) (
	input  logic                                  clk,
	input  logic                                  load,
	input  logic                                  write_request,
	input  logic [2:0]                            drive_index,
	input  logic [31:0]                           block_address,
	input  logic [7:0]                            sector_count,
	input  logic [ata_tfb_pkg::FLAG_W*NUM_DRIVES-1:0] drive_flags,
	input  logic [NUM_DRIVES-1:0][31:0]           capacity,
	output ata_tfb_pkg::checked_req_t             req_s2
);

	localparam logic [2:0] DRIVE_LIMIT = 3'(NUM_DRIVES);

	logic [ata_tfb_pkg::FLAG_W-1:0] flags;
	logic [31:0]                    cap;
	logic                           present;
	logic                           over;
	logic [32:0]                    range_end;
	logic [63:0]                    product;
	ata_tfb_pkg::checked_req_t      req;

	// Select the drive entry addressed by the request.
	always_comb begin
		flags = '0;
		cap   = '0;
		for (int i = 0; i < NUM_DRIVES; i++) begin
			if (drive_index == 3'(i)) begin
				flags = drive_flags[ata_tfb_pkg::FLAG_W*i +: ata_tfb_pkg::FLAG_W];
				cap   = capacity[i];
			end
		end
	end

	// Presence and range check; the end sector is formed at 33 bits.
	assign present   = (drive_index < DRIVE_LIMIT) && flags[ata_tfb_pkg::FLAG_PRESENT];
	assign range_end = {1'b0, block_address} + {25'b0, sector_count};
	assign over      = range_end > {1'b0, cap};

	// Quotient estimate of the address by 63, at most one below the true value.
	assign product = {32'b0, block_address} * {32'b0, ata_tfb_pkg::RECIP_63};

	always_comb begin
		req.error_code    = ata_tfb_pkg::ERR_NONE;
		if (!present) begin
			req.error_code = ata_tfb_pkg::ERR_NOT_FOUND;
		end else if (over) begin
			req.error_code = ata_tfb_pkg::ERR_RANGE;
		end
		req.channel       = flags[ata_tfb_pkg::FLAG_CHANNEL];
		req.slave         = flags[ata_tfb_pkg::FLAG_SLAVE];
		if (flags[ata_tfb_pkg::FLAG_LBA48]) begin
			req.mode = ata_tfb_pkg::MODE_LBA48;
		end else if (flags[ata_tfb_pkg::FLAG_LBA]) begin
			req.mode = ata_tfb_pkg::MODE_LBA28;
		end else begin
			req.mode = ata_tfb_pkg::MODE_CHS;
		end
		req.write_request = write_request;
		req.sector_count  = sector_count;
		req.block_address = block_address;
		req.quot_est      = product[ata_tfb_pkg::RECIP_SHIFT +: ata_tfb_pkg::QUOT_W];
	end

	// Stage two register.
	always_ff @(posedge clk) begin
		if (load) begin
			req_s2 <= req;
		end
	end

endmodule

>>> hw/rtl/ata_tfb_format.sv
module ata_tfb_format (
	input  logic                      clk,
	input  logic                      load,
	input  ata_tfb_pkg::checked_req_t req_s2,
	output ata_tfb_pkg::taskfile_t    res_s3
);

	logic [31:0]                    prod_63;
	logic [31:0]                    diff;
	logic [6:0]                     rem_est;
	logic [5:0]                     rem;
	logic [ata_tfb_pkg::QUOT_W-1:0] quot;
	logic [7:0]                     dev;
	ata_tfb_pkg::taskfile_t         res;

	// Correct the quotient estimate by one compare and subtract.
	assign prod_63 = 32'({req_s2.quot_est, 6'b0}) - 32'(req_s2.quot_est);
	assign diff    = req_s2.block_address - prod_63;
	assign rem_est = diff[6:0];

	always_comb begin
		if (rem_est >= ata_tfb_pkg::SPT) begin
			quot = req_s2.quot_est + 1'b1;
			rem  = 6'(rem_est - ata_tfb_pkg::SPT);
		end else begin
			quot = req_s2.quot_est;
			rem  = rem_est[5:0];
		end
	end

	// Build the task-file values for the chosen addressing mode.
	always_comb begin
		res = '0;
		dev = '0;
		if (req_s2.error_code != ata_tfb_pkg::ERR_NONE) begin
			res.error_code = req_s2.error_code;
		end else begin
			res.error_code     = ata_tfb_pkg::ERR_NONE;
			res.channel_select = req_s2.channel;
			res.address_mode   = req_s2.mode;
			res.count_byte     = req_s2.sector_count;
			case (req_s2.mode)
				ata_tfb_pkg::MODE_LBA48: begin
					res.address_byte0 = req_s2.block_address[7:0];
					res.address_byte1 = req_s2.block_address[15:8];
					res.address_byte2 = req_s2.block_address[23:16];
					res.address_byte3 = req_s2.block_address[31:24];
					dev = ata_tfb_pkg::DEV_LBA;
				end
				ata_tfb_pkg::MODE_LBA28: begin
					res.address_byte0 = req_s2.block_address[7:0];
					res.address_byte1 = req_s2.block_address[15:8];
					res.address_byte2 = req_s2.block_address[23:16];
					dev = ata_tfb_pkg::DEV_LBA | {4'b0, req_s2.block_address[27:24]};
				end
				default: begin
					// CHS: the head is the quotient modulo 16, the cylinder the rest.
					res.address_byte0 = {2'b0, rem} + 8'd1;
					res.address_byte1 = quot[11:4];
					res.address_byte2 = quot[19:12];
					dev = ata_tfb_pkg::DEV_CHS | {4'b0, quot[3:0]};
				end
			endcase
			res.device_select = dev | {3'b0, req_s2.slave, 4'b0};
			if (req_s2.write_request) begin
				res.command_byte  = (req_s2.mode == ata_tfb_pkg::MODE_LBA48) ?
					ata_tfb_pkg::CMD_WRITE_EXT : ata_tfb_pkg::CMD_WRITE;
				res.flush_command = (req_s2.mode == ata_tfb_pkg::MODE_LBA48) ?
					ata_tfb_pkg::CMD_FLUSH_EXT : ata_tfb_pkg::CMD_FLUSH;
			end else begin
				res.command_byte  = (req_s2.mode == ata_tfb_pkg::MODE_LBA48) ?
					ata_tfb_pkg::CMD_READ_EXT : ata_tfb_pkg::CMD_READ;
				res.flush_command = ata_tfb_pkg::CMD_NONE;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (load) begin
			res_s3 <= res;
		end
	end

endmodule

>>> hw/rtl/ata_taskfile_builder_top.sv
// ATA task-file builder: turns a sector request into task-file register values.
// Three register stages (input, reciprocal multiply, output): the input word is
// registered in the input stage, then in the multiply stage, then in the output stage.
// Throughput: one word per cycle; an empty stage always loads, so the input stalls
// only when all three stages hold words and the output word is not taken.
// Reset clears the stage valid bits and all configuration registers to zero.
module ata_taskfile_builder_top #(
	parameter int NUM_DRIVES = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port.
	input  logic                                  cfg_we,
	input  logic [ata_tfb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ata_tfb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// Request stream.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// s_tdata: write_request, drive_index, block_address, sector_count
	input  logic [ata_tfb_pkg::IN_DATA_W-1:0]     s_tdata,
	// Task-file stream.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// m_tdata: error_code, channel_select, address_mode, count_byte, address_byte0,
	// address_byte1, address_byte2, address_byte3, device_select, command_byte,
	// flush_command
	output logic [ata_tfb_pkg::OUT_DATA_W-1:0]    m_tdata
);

	logic [ata_tfb_pkg::FLAG_W*NUM_DRIVES-1:0] drive_flags_q;
	logic [NUM_DRIVES-1:0][31:0]               capacity_q;

	logic        valid_s1, valid_s2, valid_s3;
	logic        en1, en2, en3;
	logic        write_request_s1;
	logic [2:0]  drive_index_s1;
	logic [31:0] block_address_s1;
	logic [7:0]  sector_count_s1;

	ata_tfb_pkg::checked_req_t req_s2;
	ata_tfb_pkg::taskfile_t    res_s3;

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_flags_q <= '0;
			capacity_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index == ata_tfb_pkg::REG_DRIVE_FLAGS) begin
				drive_flags_q <= cfg_wdata[ata_tfb_pkg::FLAG_W*NUM_DRIVES-1:0];
			end
			for (int i = 0; i < NUM_DRIVES; i++) begin
				if (cfg_index == ata_tfb_pkg::REG_CAPACITY0 + 3'(i)) begin
					capacity_q[i] <= cfg_wdata;
				end
			end
		end
	end

	// Stage enables: a stage advances when it is empty or the next one advances.
	assign en3      = !valid_s3 || m_tready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= s_tvalid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (en1) begin
			write_request_s1 <= s_tdata[0];
			drive_index_s1   <= s_tdata[3:1];
			block_address_s1 <= s_tdata[35:4];
			sector_count_s1  <= s_tdata[43:36];
		end
	end

	ata_tfb_check #(
		.NUM_DRIVES(NUM_DRIVES)
	) u_check (
		.clk          (clk),
		.load         (en2),
		.write_request(write_request_s1),
		.drive_index  (drive_index_s1),
		.block_address(block_address_s1),
		.sector_count (sector_count_s1),
		.drive_flags  (drive_flags_q),
		.capacity     (capacity_q),
		.req_s2       (req_s2)
	);

	ata_tfb_format u_format (
		.clk   (clk),
		.load  (en3),
		.req_s2(req_s2),
		.res_s3(res_s3)
	);

	assign m_tvalid = valid_s3;
	assign m_tdata  = {3'b0, res_s3};

endmodule

>>> bench/ata_taskfile_builder_top_tb.sv
module ata_taskfile_builder_top_tb;

	localparam int NUM_DRIVES = 4;
	localparam int CFG_IDX_W = ata_tfb_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = ata_tfb_pkg::CFG_DATA_W;
	localparam int FLAG_W = ata_tfb_pkg::FLAG_W;
	localparam int FLAGS_W = NUM_DRIVES * FLAG_W;
	localparam int IN_DATA_W = ata_tfb_pkg::IN_DATA_W;
	localparam int OUT_DATA_W = ata_tfb_pkg::OUT_DATA_W;
	localparam int unsigned SECTORS_PER_TRACK = 63;
	localparam int unsigned HEADS = 16;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int RANDOM_PHASES = 6;
	localparam int RANDOM_ITEMS_PER_PHASE = 235;
	localparam int FLOOD_ITEMS = 40;

	// One request word, last field in the lowest bits.
	typedef struct packed {
		logic [7:0]  sector_count;
		logic [31:0] block_address;
		logic [2:0]  drive_index;
		logic        write_request;
	} request_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Register copies that the predictor works from.
	logic [FLAGS_W-1:0] drive_flags_cfg = '0;
	logic [31:0]        capacity_cfg [NUM_DRIVES];

	ata_tfb_pkg::taskfile_t pending_taskfiles [$];
	int        error_count = 0;
	int        requests_sent = 0;
	int        words_checked = 0;
	int        settings_applied = 0;
	int        quiet_cycles = 0;
	bit        tx_idle = 1'b1;
	bit        rx_idle = 1'b1;
	int        rx_hold_cycles = 0;

	ata_taskfile_builder_top #(
		.NUM_DRIVES(NUM_DRIVES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Expected task file for one request under the current register copies.
	function automatic ata_tfb_pkg::taskfile_t predict_taskfile(input request_t req);
		ata_tfb_pkg::taskfile_t tf;
		logic [4:0]  fl;
		logic [32:0] range_end;
		logic [31:0] lba;
		logic [31:0] sect;
		logic [31:0] base;
		logic [31:0] cyl;
		logic [31:0] head;
		logic [7:0]  dev;
		bit          ext;
		tf = '0;
		lba = req.block_address;
		if (req.drive_index >= NUM_DRIVES) begin
			tf.error_code = ata_tfb_pkg::ERR_NOT_FOUND;
			return tf;
		end
		fl = drive_flags_cfg[FLAG_W*req.drive_index +: FLAG_W];
		if (!fl[ata_tfb_pkg::FLAG_PRESENT]) begin
			tf.error_code = ata_tfb_pkg::ERR_NOT_FOUND;
			return tf;
		end
		// The end of the range is formed at 33 bits so it cannot wrap.
		range_end = {1'b0, lba} + {25'd0, req.sector_count};
		if (range_end > {1'b0, capacity_cfg[req.drive_index]}) begin
			tf.error_code = ata_tfb_pkg::ERR_RANGE;
			return tf;
		end
		ext = fl[ata_tfb_pkg::FLAG_LBA48];
		if (ext) begin
			tf.address_mode = ata_tfb_pkg::MODE_LBA48;
			{tf.address_byte3, tf.address_byte2, tf.address_byte1, tf.address_byte0} = lba;
			head = '0;
			dev = ata_tfb_pkg::DEV_LBA;
		end else if (fl[ata_tfb_pkg::FLAG_LBA]) begin
			tf.address_mode = ata_tfb_pkg::MODE_LBA28;
			{tf.address_byte2, tf.address_byte1, tf.address_byte0} = lba[23:0];
			head = {28'd0, lba[27:24]};
			dev = ata_tfb_pkg::DEV_LBA;
		end else begin
			// Fixed geometry of 16 heads and 63 sectors per track.
			sect = lba % SECTORS_PER_TRACK + 1;
			base = lba - (sect - 1);
			cyl = base / (HEADS * SECTORS_PER_TRACK);
			head = (base % (HEADS * SECTORS_PER_TRACK)) / SECTORS_PER_TRACK;
			tf.address_mode = ata_tfb_pkg::MODE_CHS;
			tf.address_byte0 = sect[7:0];
			tf.address_byte1 = cyl[7:0];
			tf.address_byte2 = cyl[15:8];
			dev = ata_tfb_pkg::DEV_CHS;
		end
		tf.error_code = ata_tfb_pkg::ERR_NONE;
		tf.channel_select = fl[ata_tfb_pkg::FLAG_CHANNEL];
		tf.count_byte = req.sector_count;
		tf.device_select = dev | {3'b000, fl[ata_tfb_pkg::FLAG_SLAVE], head[3:0]};
		if (req.write_request) begin
			tf.command_byte = ext ? ata_tfb_pkg::CMD_WRITE_EXT : ata_tfb_pkg::CMD_WRITE;
			tf.flush_command = ext ? ata_tfb_pkg::CMD_FLUSH_EXT : ata_tfb_pkg::CMD_FLUSH;
		end else begin
			tf.command_byte = ext ? ata_tfb_pkg::CMD_READ_EXT : ata_tfb_pkg::CMD_READ;
			tf.flush_command = ata_tfb_pkg::CMD_NONE;
		end
		return tf;
	endfunction

	function automatic request_t make_request(input logic wr, input logic [2:0] idx,
			input logic [31:0] lba, input logic [7:0] cnt);
		request_t r;
		r.write_request = wr;
		r.drive_index = idx;
		r.block_address = lba;
		r.sector_count = cnt;
		return r;
	endfunction

	// Random request, with start addresses drawn at random, around the capacity or below it.
	function automatic request_t random_request();
		request_t    r;
		logic [31:0] cap;
		logic [32:0] near_end;
		r.write_request = 1'($urandom_range(0, 1));
		r.drive_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(NUM_DRIVES, 7)) :
			3'($urandom_range(0, NUM_DRIVES - 1));
		r.sector_count = 8'($urandom_range(0, 255));
		cap = (r.drive_index < NUM_DRIVES) ? capacity_cfg[r.drive_index] : $urandom;
		case ($urandom_range(0, 3))
			0: begin
				r.block_address = $urandom;
			end
			1: begin
				near_end = {1'b0, cap} - r.sector_count + $urandom_range(0, 4) - 2;
				r.block_address = near_end[31:0];
			end
			default: begin
				r.block_address = $urandom_range(0, cap);
			end
		endcase
		return r;
	endfunction

	// Same bit set in every five-bit drive entry.
	function automatic logic [FLAGS_W-1:0] flag_mask(input int bit_pos);
		logic [FLAGS_W-1:0] m;
		m = '0;
		for (int e = 0; e < NUM_DRIVES; e++)
			m[FLAG_W*e + bit_pos] = 1'b1;
		return m;
	endfunction

	// Raises the write enable for one register; end_writes lowers it again.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == ata_tfb_pkg::REG_DRIVE_FLAGS)
			drive_flags_cfg = data[FLAGS_W-1:0];
		else if (idx >= ata_tfb_pkg::REG_CAPACITY0 &&
				idx < ata_tfb_pkg::REG_CAPACITY0 + NUM_DRIVES)
			capacity_cfg[idx - ata_tfb_pkg::REG_CAPACITY0] = data;
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_config(input logic [FLAGS_W-1:0] flags,
			input logic [31:0] caps [NUM_DRIVES]);
		write_reg(ata_tfb_pkg::REG_DRIVE_FLAGS, CFG_DATA_W'(flags));
		for (int e = 0; e < NUM_DRIVES; e++)
			write_reg(CFG_IDX_W'(ata_tfb_pkg::REG_CAPACITY0 + e), caps[e]);
		settings_applied++;
	endtask

	// Offers one request word and records its expected task file once taken.
	task automatic send_request(input request_t req);
		int gap;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - $bits(request_t)){1'b0}}, req};
		do @(posedge clk); while (!s_tready);
		pending_taskfiles.push_back(predict_taskfile(req));
		requests_sent++;
	endtask

	// Waits until every expected word has come out, then lets the pipeline settle.
	task automatic drain_pipeline();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_taskfiles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// With all registers at reset no entry is present.
	task automatic test_reset_state();
		send_request(make_request(1'b0, 3'd0, 32'd0, 8'd0));
		send_request(make_request(1'b1, 3'd3, 32'hFFFF_FFFF, 8'hFF));
		send_request(make_request(1'b0, 3'd7, 32'h0000_0001, 8'd1));
		drain_pipeline();
	endtask

	// Each address mode, reads and writes, field extremes, absent and unknown entries.
	task automatic test_address_modes();
		logic [31:0] caps [NUM_DRIVES];
		caps = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd12345};
		// Entry 0 LBA48 master, entry 1 LBA28 slave on secondary, entry 2 CHS slave,
		// entry 3 absent with every other flag set.
		apply_config({5'b11110, 5'b00101, 5'b10111, 5'b11001}, caps);
		end_writes();
		send_request(make_request(1'b0, 3'd0, 32'd0, 8'd0));
		send_request(make_request(1'b1, 3'd0, 32'hFFFF_FFFF, 8'd0));
		send_request(make_request(1'b0, 3'd0, 32'hFFFF_FFFF, 8'd1));
		send_request(make_request(1'b1, 3'd0, 32'hFFFF_FF00, 8'hFF));
		send_request(make_request(1'b0, 3'd1, 32'hFFFF_FFFF, 8'd0));
		send_request(make_request(1'b1, 3'd1, 32'h0ABC_DEF1, 8'hFF));
		send_request(make_request(1'b0, 3'd2, 32'd0, 8'd1));
		send_request(make_request(1'b1, 3'd2, 32'd62, 8'd1));
		send_request(make_request(1'b0, 3'd2, 32'd63, 8'd2));
		send_request(make_request(1'b1, 3'd2, 32'd1007, 8'd3));
		send_request(make_request(1'b0, 3'd2, 32'd1008, 8'd4));
		send_request(make_request(1'b1, 3'd2, 32'hFFFF_FFFF, 8'd0));
		send_request(make_request(1'b0, 3'd2, 32'hAAAA_AAAA, 8'h55));
		send_request(make_request(1'b0, 3'd3, 32'd5, 8'd1));
		send_request(make_request(1'b1, 3'd3, 32'd5, 8'd1));
		for (int i = NUM_DRIVES; i < 8; i++)
			send_request(make_request(i[0], i[2:0], 32'd0, 8'd0));
		drain_pipeline();
	endtask

	// Ranges that end exactly at the capacity and one sector past it; writes to
	// indexes past the register list must leave everything unchanged.
	task automatic test_capacity_edges();
		logic [31:0] caps [NUM_DRIVES];
		caps = '{32'd0, 32'd1, 32'd255, 32'h8000_0000};
		apply_config({FLAGS_W{1'b1}}, caps);
		for (int i = ata_tfb_pkg::REG_CAPACITY0 + NUM_DRIVES; i < 2**CFG_IDX_W; i++)
			write_reg(i[CFG_IDX_W-1:0], 32'h5555_5555);
		end_writes();
		send_request(make_request(1'b0, 3'd0, 32'd0, 8'd0));
		send_request(make_request(1'b1, 3'd0, 32'd0, 8'd1));
		send_request(make_request(1'b0, 3'd1, 32'd1, 8'd0));
		send_request(make_request(1'b1, 3'd1, 32'd1, 8'd1));
		send_request(make_request(1'b0, 3'd2, 32'd0, 8'hFF));
		send_request(make_request(1'b1, 3'd2, 32'd1, 8'hFF));
		send_request(make_request(1'b0, 3'd3, 32'h7FFF_FF01, 8'hFF));
		send_request(make_request(1'b1, 3'd3, 32'h7FFF_FF02, 8'hFF));
		drain_pipeline();
	endtask

	// Random requests over several register settings and idling patterns.
	task automatic test_random_traffic();
		logic [FLAGS_W-1:0] flags;
		logic [31:0]        caps [NUM_DRIVES];
		int                 items;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			items = RANDOM_ITEMS_PER_PHASE;
			case (phase)
				0: begin
					flags = '1;
					caps = '{default: 32'hFFFF_FFFF};
				end
				1: begin
					flags = FLAGS_W'($urandom);
					foreach (caps[e]) caps[e] = $urandom;
				end
				2: begin
					flags = (FLAGS_W'($urandom) | flag_mask(ata_tfb_pkg::FLAG_PRESENT) |
						flag_mask(ata_tfb_pkg::FLAG_LBA)) & ~flag_mask(ata_tfb_pkg::FLAG_LBA48);
					foreach (caps[e]) caps[e] = $urandom;
				end
				3: begin
					flags = (FLAGS_W'($urandom) | flag_mask(ata_tfb_pkg::FLAG_PRESENT)) &
						~(flag_mask(ata_tfb_pkg::FLAG_LBA48) | flag_mask(ata_tfb_pkg::FLAG_LBA));
					caps = '{default: 32'hFFFF_FFFF};
				end
				4: begin
					flags = FLAGS_W'($urandom) | flag_mask(ata_tfb_pkg::FLAG_PRESENT);
					foreach (caps[e]) caps[e] = $urandom_range(0, 1000);
				end
				default: begin
					flags = '0;
					caps = '{default: 32'd0};
					items = RANDOM_ITEMS_PER_PHASE / 4;
				end
			endcase
			apply_config(flags, caps);
			end_writes();
			tx_idle = (phase % 3 != 0);
			rx_idle = (phase % 3 != 1);
			repeat (items) send_request(random_request());
			drain_pipeline();
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// The receiver holds off for a long stretch while requests keep coming,
	// so the pipeline fills and stalls its input.
	task automatic test_output_backpressure();
		logic [31:0] caps [NUM_DRIVES];
		caps = '{default: 32'hFFFF_FFFF};
		apply_config(FLAGS_W'($urandom) | flag_mask(ata_tfb_pkg::FLAG_PRESENT), caps);
		end_writes();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold_cycles = HOLD_OFF_CYCLES;
		repeat (FLOOD_ITEMS) send_request(random_request());
		drain_pipeline();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Receiver: a random pause before each word while rx_idle is set, or a long hold when asked.
	initial begin
		int stall;
		forever begin
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				stall = rx_idle ? $urandom_range(0, 9) : 0;
			end
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	// Each task-file word against the oldest expected one.
	always @(posedge clk) begin
		ata_tfb_pkg::taskfile_t got;
		ata_tfb_pkg::taskfile_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(ata_tfb_pkg::taskfile_t)-1:0];
			if (pending_taskfiles.size() == 0) begin
				$error("task-file word 0x%0h with no request outstanding", m_tdata);
				error_count++;
			end else begin
				want = pending_taskfiles.pop_front();
				words_checked++;
				check_field("error_code", 32'(want.error_code), 32'(got.error_code));
				check_field("channel_select", 32'(want.channel_select),
					32'(got.channel_select));
				check_field("address_mode", 32'(want.address_mode), 32'(got.address_mode));
				check_field("count_byte", 32'(want.count_byte), 32'(got.count_byte));
				check_field("address_byte0", 32'(want.address_byte0),
					32'(got.address_byte0));
				check_field("address_byte1", 32'(want.address_byte1),
					32'(got.address_byte1));
				check_field("address_byte2", 32'(want.address_byte2),
					32'(got.address_byte2));
				check_field("address_byte3", 32'(want.address_byte3),
					32'(got.address_byte3));
				check_field("device_select", 32'(want.device_select),
					32'(got.device_select));
				check_field("command_byte", 32'(want.command_byte), 32'(got.command_byte));
				check_field("flush_command", 32'(want.flush_command),
					32'(got.flush_command));
			end
		end
	end

	// Ends the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		foreach (capacity_cfg[e]) capacity_cfg[e] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_address_modes();
		test_capacity_edges();
		test_random_traffic();
		test_output_backpressure();
		$display("Checked %0d task-file words for %0d requests over %0d register settings,",
			words_checked, requests_sent, settings_applied);
		$display("covering all address modes, absent entries, capacity edges and stalls.");
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
